// ===== design/hct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hct_pkg
// Types and constants shared by the hash count table files.
// ----------------------------------------------------------------------------
package hct_pkg;

    localparam int SLOTS   = 4096;
    localparam int SLOT_W  = 12;
    localparam int COUNT_W = 13;
    localparam int KEY_W   = 64;
    localparam int CNT_W   = 32;

    localparam logic [KEY_W-1:0] MIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [KEY_W-1:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
    localparam int               MIX_SHIFT = 33;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 13'd2868;

    localparam int  PADDR_W        = 3;
    localparam logic REG_LOAD_LIMIT = 1'b0;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_UPDATED  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_DONE     = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  increment;
        logic [SLOT_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [CNT_W-1:0]   count_out;
        logic [KEY_W-1:0]   key_out;
        logic               slot_valid;
        logic [SLOT_W-1:0]  slot_out;
        logic [COUNT_W-1:0] used_count;
    } rsp_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } entry_t;

endpackage

// ===== design/hct_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hct_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/hash_count_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_count_table_core
// Counting hash table, 4096 slots of 64-bit key and 32-bit count, linear
// probing from the fmix64 home slot.
// ----------------------------------------------------------------------------
// One request is handled at a time; the slots live in a single RAM of
// {valid, key, count} words with a registered read port. An add computes
// the hash (two 64-bit multiplies done as three 32x32 partial products
// each on one shared multiplier), starts the probe, checks one slot at a
// time until it finds the key, a free slot or has probed all, then posts
// the result once the output is free. A read slot request reads the slot
// and posts it. A clear request sweeps the RAM one slot per cycle, and the
// same sweep runs after reset; req_stall is high meanwhile, while
// load_limit writes are taken as usual. A finished result waits in the
// output register without blocking the next request.
// ----------------------------------------------------------------------------
module hash_count_table_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  hct_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output hct_pkg::rsp_t                  rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hct_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_CHECK,
        S_READ,
        S_EMIT
    } state_t;

    localparam int ENTRY_W = $bits(hct_pkg::entry_t);

    state_t                          state_reg, state_next;
    logic                            sweep_rsp_reg, sweep_rsp_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic [hct_pkg::COUNT_W-1:0]     occ_reg, occ_next;
    logic [hct_pkg::COUNT_W-1:0]     limit_reg, limit_next;
    logic [hct_pkg::SLOT_W-1:0]      addr_reg, addr_next;
    logic [hct_pkg::SLOT_W-1:0]      probe_reg, probe_next;
    logic [1:0]                      mstep_reg, mstep_next;
    logic                            pass_reg, pass_next;

    logic [hct_pkg::KEY_W-1:0]       hash_reg, hash_next;
    logic [63:0]                     prod_reg, prod_next;
    logic [63:0]                     acc_reg, acc_next;
    logic [hct_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [hct_pkg::CNT_W-1:0]       inc_reg, inc_next;
    hct_pkg::rsp_t                   res_reg, res_next;
    hct_pkg::rsp_t                   rsp_reg, rsp_next;

    logic                            mem_we, mem_re;
    logic [hct_pkg::SLOT_W-1:0]      mem_waddr, mem_raddr;
    hct_pkg::entry_t                 mem_wdata, mem_rdata;
    logic [ENTRY_W-1:0]              mem_rdata_raw;

    logic [31:0]                     mul_x, mul_y;
    logic [63:0]                     mul_prod;
    logic [hct_pkg::KEY_W-1:0]       mix_c;
    logic [63:0]                     mix_sum, mix_out;
    logic [hct_pkg::CNT_W-1:0]       sum_cnt;
    logic                            cfg_wr;

    hct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (hct_pkg::SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata_raw)
    );

    assign mem_rdata = hct_pkg::entry_t'(mem_rdata_raw);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == hct_pkg::REG_LOAD_LIMIT);
    assign prdata = (paddr[2] == hct_pkg::REG_LOAD_LIMIT)
                    ? {{(32-hct_pkg::COUNT_W){1'b0}}, limit_reg} : 32'd0;

    // 64x64 low product as three 32x32 partial products
    assign mix_c = pass_reg ? hct_pkg::MIX_C2 : hct_pkg::MIX_C1;

    always_comb
    begin
        unique case (mstep_reg)
            2'd0:
            begin
                mul_x = hash_reg[31:0];
                mul_y = mix_c[31:0];
            end
            2'd1:
            begin
                mul_x = hash_reg[31:0];
                mul_y = mix_c[63:32];
            end
            default:
            begin
                mul_x = hash_reg[63:32];
                mul_y = mix_c[31:0];
            end
        endcase
    end

    assign mul_prod = {32'd0, mul_x} * {32'd0, mul_y};
    assign mix_sum  = acc_reg + {prod_reg[31:0], 32'd0};
    assign mix_out  = mix_sum ^ (mix_sum >> hct_pkg::MIX_SHIFT);
    assign sum_cnt  = mem_rdata.count + inc_reg;

    always_comb
    begin
        state_next     = state_reg;
        sweep_rsp_next = sweep_rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        occ_next       = occ_reg;
        limit_next     = cfg_wr ? pwdata[hct_pkg::COUNT_W-1:0] : limit_reg;
        addr_next      = addr_reg;
        probe_next     = probe_reg;
        mstep_next     = mstep_reg;
        pass_next      = pass_reg;
        hash_next      = hash_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        key_next       = key_reg;
        inc_next       = inc_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;

        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = addr_reg;

        unique case (state_reg)
            S_SWEEP:
            begin
                mem_we    = 1'b1;
                addr_next = hct_pkg::SLOT_W'(addr_reg + 1'b1);
                if (addr_reg == '1)
                begin
                    if (sweep_rsp_reg)
                    begin
                        res_next            = '0;
                        res_next.status     = hct_pkg::ST_DONE;
                        state_next          = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    key_next   = req.key;
                    inc_next   = req.increment;
                    hash_next  = req.key ^ (req.key >> hct_pkg::MIX_SHIFT);
                    mstep_next = 2'd0;
                    pass_next  = 1'b0;
                    unique case (req.req_type)
                        hct_pkg::REQ_ADD:
                        begin
                            state_next = S_HASH;
                        end
                        hct_pkg::REQ_READ:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = req.slot_index;
                            state_next = S_READ;
                        end
                        hct_pkg::REQ_CLEAR:
                        begin
                            addr_next      = '0;
                            occ_next       = '0;
                            sweep_rsp_next = 1'b1;
                            state_next     = S_SWEEP;
                        end
                        default:
                        begin
                            res_next            = '0;
                            res_next.status     = hct_pkg::ST_DONE;
                            res_next.used_count = occ_reg;
                            state_next          = S_EMIT;
                        end
                    endcase
                end
            end

            S_HASH:
            begin
                prod_next  = mul_prod;
                mstep_next = mstep_reg + 2'd1;
                unique case (mstep_reg)
                    2'd0:
                    begin
                    end
                    2'd1:
                    begin
                        acc_next = prod_reg;
                    end
                    2'd2:
                    begin
                        acc_next = mix_sum;
                    end
                    default:
                    begin
                        if (!pass_reg)
                        begin
                            hash_next = mix_out;
                            pass_next = 1'b1;
                        end
                        else
                        begin
                            addr_next  = mix_out[hct_pkg::SLOT_W-1:0];
                            probe_next = '0;
                            state_next = S_PROBE;
                        end
                    end
                endcase
            end

            S_PROBE:
            begin
                mem_re     = 1'b1;
                mem_raddr  = addr_reg;
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                // next slot is fetched ahead, used only on a miss
                mem_re    = 1'b1;
                mem_raddr = hct_pkg::SLOT_W'(addr_reg + 1'b1);
                res_next  = '0;
                if (!mem_rdata.valid)
                begin
                    if (occ_reg >= limit_reg)
                    begin
                        res_next.status     = hct_pkg::ST_FULL;
                        res_next.used_count = occ_reg;
                    end
                    else
                    begin
                        mem_we              = 1'b1;
                        mem_wdata.valid     = 1'b1;
                        mem_wdata.key       = key_reg;
                        mem_wdata.count     = inc_reg;
                        occ_next            = hct_pkg::COUNT_W'(occ_reg + 1'b1);
                        res_next.status     = hct_pkg::ST_INSERTED;
                        res_next.count_out  = inc_reg;
                        res_next.slot_out   = addr_reg;
                        res_next.used_count = hct_pkg::COUNT_W'(occ_reg + 1'b1);
                    end
                    state_next = S_EMIT;
                end
                else if (mem_rdata.key == key_reg)
                begin
                    mem_we              = 1'b1;
                    mem_wdata.valid     = 1'b1;
                    mem_wdata.key       = key_reg;
                    mem_wdata.count     = sum_cnt;
                    res_next.status     = hct_pkg::ST_UPDATED;
                    res_next.count_out  = sum_cnt;
                    res_next.slot_out   = addr_reg;
                    res_next.used_count = occ_reg;
                    state_next          = S_EMIT;
                end
                else if (probe_reg == '1)
                begin
                    res_next.status     = hct_pkg::ST_FULL;
                    res_next.used_count = occ_reg;
                    state_next          = S_EMIT;
                end
                else
                begin
                    addr_next  = hct_pkg::SLOT_W'(addr_reg + 1'b1);
                    probe_next = hct_pkg::SLOT_W'(probe_reg + 1'b1);
                end
            end

            S_READ:
            begin
                res_next            = '0;
                res_next.status     = hct_pkg::ST_DONE;
                res_next.used_count = occ_reg;
                if (mem_rdata.valid)
                begin
                    res_next.slot_valid = 1'b1;
                    res_next.key_out    = mem_rdata.key;
                    res_next.count_out  = mem_rdata.count;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sweep_rsp_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            occ_reg       <= '0;
            limit_reg     <= hct_pkg::LIMIT_RESET;
            addr_reg      <= '0;
            probe_reg     <= '0;
            mstep_reg     <= '0;
            pass_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_rsp_reg <= sweep_rsp_next;
            rsp_valid_reg <= rsp_valid_next;
            occ_reg       <= occ_next;
            limit_reg     <= limit_next;
            addr_reg      <= addr_next;
            probe_reg     <= probe_next;
            mstep_reg     <= mstep_next;
            pass_reg      <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        key_reg  <= key_next;
        inc_reg  <= inc_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks hash_count_table_core against a predictor of the counting table that
// is updated on every accepted request word and compared field by field with
// every result word. Directed adds cover the key and increment extremes,
// count wrap, unused request codes and load limits 0 and 1. Random traffic
// follows under several load limits and idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 20000;
    localparam int         PHASE_WORDS = 228;
    localparam int         POOL_DEPTH  = 512;

    class count_table_scoreboard;
        logic [hct_pkg::KEY_W-1:0]   keys [hct_pkg::SLOTS];
        logic [hct_pkg::CNT_W-1:0]   counts [hct_pkg::SLOTS];
        bit                          in_use [hct_pkg::SLOTS];
        bit                          touched [hct_pkg::SLOTS];
        int unsigned                 touched_slots [$];
        logic [hct_pkg::COUNT_W-1:0] occupancy;
        logic [hct_pkg::COUNT_W-1:0] limit;
        hct_pkg::rsp_t               expected_q [$];
        int                          errors;
        int                          inserts;
        int                          updates;
        int                          refusals;
        int                          reads;
        int                          clears;

        function new();
            occupancy = '0;
            limit     = hct_pkg::LIMIT_RESET;
            errors    = 0;
            inserts   = 0;
            updates   = 0;
            refusals  = 0;
            reads     = 0;
            clears    = 0;
        endfunction

        function logic [hct_pkg::SLOT_W-1:0] home_slot(logic [hct_pkg::KEY_W-1:0] k);
            logic [hct_pkg::KEY_W-1:0] v;
            v = k;
            v = v ^ (v >> hct_pkg::MIX_SHIFT);
            v = v * hct_pkg::MIX_C1;
            v = v ^ (v >> hct_pkg::MIX_SHIFT);
            v = v * hct_pkg::MIX_C2;
            v = v ^ (v >> hct_pkg::MIX_SHIFT);
            return v[hct_pkg::SLOT_W-1:0];
        endfunction

        function void note_request(hct_pkg::req_t r);
            hct_pkg::rsp_t e;
            int unsigned   pos;
            int            n;
            bit            hit;
            bit            hole;
            e = '0;
            e.status = hct_pkg::ST_DONE;
            case (r.req_type)
                hct_pkg::REQ_ADD:
                begin
                    pos  = 32'(home_slot(r.key));
                    n    = 0;
                    hit  = 1'b0;
                    hole = 1'b0;
                    while (n < hct_pkg::SLOTS && !hit && !hole)
                    begin
                        if (!in_use[pos])
                            hole = 1'b1;
                        else if (keys[pos] == r.key)
                            hit = 1'b1;
                        else
                        begin
                            pos = (pos + 1) % hct_pkg::SLOTS;
                            n++;
                        end
                    end
                    if (hit)
                    begin
                        counts[pos] = counts[pos] + r.increment;
                        e.status    = hct_pkg::ST_UPDATED;
                        e.count_out = counts[pos];
                        e.slot_out  = pos[hct_pkg::SLOT_W-1:0];
                        updates++;
                    end
                    else if (!hole || occupancy >= limit)
                    begin
                        e.status = hct_pkg::ST_FULL;
                        refusals++;
                    end
                    else
                    begin
                        in_use[pos] = 1'b1;
                        keys[pos]   = r.key;
                        counts[pos] = r.increment;
                        if (!touched[pos])
                        begin
                            touched[pos] = 1'b1;
                            touched_slots.insert(touched_slots.size(), pos);
                        end
                        occupancy   = occupancy + 1'b1;
                        e.status    = hct_pkg::ST_INSERTED;
                        e.count_out = r.increment;
                        e.slot_out  = pos[hct_pkg::SLOT_W-1:0];
                        inserts++;
                    end
                end
                hct_pkg::REQ_READ:
                begin
                    if (in_use[r.slot_index])
                    begin
                        e.slot_valid = 1'b1;
                        e.key_out    = keys[r.slot_index];
                        e.count_out  = counts[r.slot_index];
                    end
                    reads++;
                end
                hct_pkg::REQ_CLEAR:
                begin
                    foreach (in_use[i])
                        in_use[i] = 1'b0;
                    occupancy = '0;
                    clears++;
                end
                default: ;
            endcase
            e.used_count = occupancy;
            expected_q.insert(expected_q.size(), e);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t ns mismatch %s: got %h expected %h", $time, what, got, want);
            errors++;
        endtask

        task check_result(hct_pkg::rsp_t got);
            hct_pkg::rsp_t e;
            if (expected_q.size() == 0)
            begin
                report("unexpected word", 64'(got.status), 64'd0);
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status)
                report("status", 64'(got.status), 64'(e.status));
            if (got.count_out !== e.count_out)
                report("count_out", 64'(got.count_out), 64'(e.count_out));
            if (got.key_out !== e.key_out)
                report("key_out", got.key_out, e.key_out);
            if (got.slot_valid !== e.slot_valid)
                report("slot_valid", 64'(got.slot_valid), 64'(e.slot_valid));
            if (got.slot_out !== e.slot_out)
                report("slot_out", 64'(got.slot_out), 64'(e.slot_out));
            if (got.used_count !== e.used_count)
                report("used_count", 64'(got.used_count), 64'(e.used_count));
        endtask
    endclass

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        req_valid = 1'b0;
    logic                        req_stall;
    hct_pkg::req_t               req       = '0;
    logic                        rsp_valid;
    logic                        rsp_stall = 1'b0;
    hct_pkg::rsp_t               rsp;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [hct_pkg::PADDR_W-1:0] paddr     = '0;
    logic [31:0]                 pwdata    = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    count_table_scoreboard       sb;
    int                          send_idle_pct = 9;
    int                          recv_idle_pct = 69;
    int                          quiet_cycles  = 0;
    logic [hct_pkg::KEY_W-1:0]   key_pool [$];

    hash_count_table_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_result(rsp);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function hct_pkg::req_t make_req(logic [1:0] kind, logic [hct_pkg::KEY_W-1:0] k,
                                     logic [hct_pkg::CNT_W-1:0] inc,
                                     logic [hct_pkg::SLOT_W-1:0] idx);
        hct_pkg::req_t r;
        r.req_type   = kind;
        r.key        = k;
        r.increment  = inc;
        r.slot_index = idx;
        return r;
    endfunction

    function hct_pkg::req_t random_request();
        hct_pkg::req_t r;
        int            pick;
        r = make_req(hct_pkg::REQ_ADD, {$urandom, $urandom}, $urandom,
                     hct_pkg::SLOT_W'($urandom));
        pick = $urandom_range(99);
        if (pick >= 92)
            r.req_type = REQ_UNUSED;
        else if (pick >= 91)
            r.req_type = hct_pkg::REQ_CLEAR;
        else if (pick >= 70 && sb.touched_slots.size() != 0)
        begin
            r.req_type   = hct_pkg::REQ_READ;
            r.slot_index = hct_pkg::SLOT_W'(
                sb.touched_slots[$urandom_range(sb.touched_slots.size() - 1)]);
        end
        else
        begin
            case ($urandom_range(9))
                0: r.key = '0;
                1: r.key = '1;
                2, 3, 4, 5:
                begin
                    if (key_pool.size() != 0)
                        r.key = key_pool[$urandom_range(key_pool.size() - 1)];
                end
                default:
                begin
                    key_pool.insert(key_pool.size(), r.key);
                    if (key_pool.size() > POOL_DEPTH)
                        void'(key_pool.pop_front());
                end
            endcase
            case ($urandom_range(9))
                0: r.increment = '0;
                1: r.increment = 32'hFFFF_FFFF - $urandom_range(3);
                default: ;
            endcase
        end
        return r;
    endfunction

    task send_word(input hct_pkg::req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task settle();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_q.size() != 0);
    endtask

    task write_limit(input logic [hct_pkg::COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {hct_pkg::REG_LOAD_LIMIT, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.limit = value;
    endtask

    initial
    begin
        logic [hct_pkg::KEY_W-1:0] k;
        int                        n;
        int                        phase;

        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, count wrap, reads before and after clear, unused code
        send_word(make_req(hct_pkg::REQ_ADD, '0, '0, '0));
        send_word(make_req(hct_pkg::REQ_ADD, '1, '1, '1));
        send_word(make_req(hct_pkg::REQ_ADD, '1, 32'd1, '0));
        send_word(make_req(hct_pkg::REQ_ADD, '0, '1, '1));
        send_word(make_req(hct_pkg::REQ_READ, '1, '1,
                           hct_pkg::SLOT_W'(sb.touched_slots[0])));
        send_word(make_req(hct_pkg::REQ_READ, '0, '0,
                           hct_pkg::SLOT_W'(sb.touched_slots[1])));
        send_word(make_req(REQ_UNUSED, '1, '1, '1));
        send_word(make_req(hct_pkg::REQ_ADD, {$urandom, $urandom}, 32'h8000_0000, '0));
        send_word(make_req(hct_pkg::REQ_CLEAR, '1, '1, '1));
        send_word(make_req(hct_pkg::REQ_READ, '0, '0,
                           hct_pkg::SLOT_W'(sb.touched_slots[0])));
        send_word(make_req(hct_pkg::REQ_ADD, '0, 32'd5, '0));

        // limit 0 refuses every new key but still updates
        settle();
        write_limit(13'd0);
        send_word(make_req(hct_pkg::REQ_ADD, {$urandom, $urandom}, $urandom, '0));
        send_word(make_req(hct_pkg::REQ_ADD, '0, 32'd7, '0));

        settle();
        write_limit(13'd1);
        send_word(make_req(hct_pkg::REQ_ADD, {$urandom, $urandom}, $urandom, '1));
        send_word(make_req(hct_pkg::REQ_CLEAR, '0, '0, '0));
        k = {$urandom, $urandom};
        send_word(make_req(hct_pkg::REQ_ADD, k, $urandom, '0));
        send_word(make_req(hct_pkg::REQ_ADD, {$urandom, $urandom}, $urandom, '0));
        send_word(make_req(hct_pkg::REQ_ADD, k, $urandom, '1));
        send_word(make_req(REQ_UNUSED, '0, '0, '0));

        for (phase = 0; phase < 6; phase++)
        begin
            settle();
            case (phase)
                0: write_limit(13'd1);
                1: write_limit(13'd4096);
                2: write_limit(13'd48);
                3: write_limit(hct_pkg::LIMIT_RESET);
                4: write_limit(13'($urandom_range(2, 600)));
                default: write_limit(13'h1FFF);
            endcase
            send_idle_pct = (phase < 2) ? 9 : (phase < 4) ? 69 : 0;
            recv_idle_pct = (phase < 2) ? 69 : (phase < 4) ? 9 : 0;
            if (phase % 2 == 0)
                send_word(make_req(hct_pkg::REQ_CLEAR, {$urandom, $urandom}, $urandom,
                                   hct_pkg::SLOT_W'($urandom)));
            for (n = 0; n < PHASE_WORDS; n++)
                send_word(random_request());
        end

        settle();
        repeat (40) @(posedge clk);
        $display("%0d inserts, %0d updates, %0d refused full, %0d slot reads, %0d clears",
                 sb.inserts, sb.updates, sb.refusals, sb.reads, sb.clears);
        $display("load limits from 0 up to 8191 applied under three idling patterns");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
